// ===== src/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 package
// shared constants, types and round tables for the sha-256 digest core
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WordW      = 32;
  localparam int VbW        = 3;
  localparam int InTdataW   = 40;   // data_word + valid_bytes, padded to bytes
  localparam int LenW       = 61;
  localparam int QueueDepth = 2;

  localparam logic [31:0] PadWord = 32'h8000_0000;
  localparam logic [7:0]  PadByte = 8'h80;

  // queued word kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,   // full message word
    KIND_LAST = 2'd1    // final word, padding follows
  } kind_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  vbytes;
    kind_t       kind;
  } qitem_t;

  typedef enum logic [2:0] {
    ST_FEED  = 3'd0,   // take words from the queue
    ST_ROUND = 3'd1,   // 64 compression rounds
    ST_ADD   = 3'd2,   // fold working vars into chain
    ST_PAD   = 3'd3,   // generate padding words
    ST_EMIT  = 3'd4    // send digest words
  } state_t;

  typedef struct packed {
    logic        pad_full;   // last word had four bytes, pad word still owed
  } padinfo_t;

  function automatic logic [31:0] k_of(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
        6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
        6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
        6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
        6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] h_init(input logic [2:0] i);
    logic [31:0] h;
    begin
      case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

endpackage

// ===== src/sha256_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 front
// accepts message words, clamps byte counts, classifies and queues them
// ----------------------------------------------------------------------------
module sha256_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_data,
  input  logic [2:0]          in_vbytes,
  input  logic                in_last,
  output logic                q_valid,
  input  logic                q_ready,
  output sha256_pkg::qitem_t  q_item
);
  import sha256_pkg::*;

  qitem_t       mem_r [QueueDepth];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push, pop;
  qitem_t       item;

  always_comb begin
    item.data   = in_data;
    item.vbytes = (in_vbytes > 3'd4) ? 3'd4 : in_vbytes;
    item.kind   = in_last ? KIND_LAST : KIND_DATA;
    if (!in_last) begin
      item.vbytes = 3'd4;
    end
  end

  assign in_ready = (cnt_r != 2'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QueueDepth)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QueueDepth) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");

endmodule

// ===== src/sha256_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 back
// block gathering, padding, 64-round compression and digest output
// ----------------------------------------------------------------------------
module sha256_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  sha256_pkg::qitem_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_data,
  output logic                out_last
);
  import sha256_pkg::*;

  state_t       state_r, state_nxt;
  logic [31:0]  h_r [8];
  logic [31:0]  w_r [16];          // block buffer, then schedule window
  logic [31:0]  v_r [8];           // a..h
  logic [3:0]   wcnt_r;
  logic [5:0]   rnd_r;
  logic [LenW-1:0] len_r;
  logic         fin_r;             // block is the final one
  logic         padfull_r;
  logic         tail_r;            // last word taken, padding under way
  logic [2:0]   ocnt_r;
  logic [31:0]  h_add [8];

  // word insertion
  logic         ins;
  logic [31:0]  ins_word;
  logic         take;

  // round datapath
  logic [31:0] a, b, c, d, e, f, g, h, wt, s0, s1, ch, mj, t1, t2, sw0, sw1, wnew;
  logic [5:0]  bits_sh;

  always_comb begin
    a = v_r[0]; b = v_r[1]; c = v_r[2]; d = v_r[3];
    e = v_r[4]; f = v_r[5]; g = v_r[6]; h = v_r[7];
    sw0  = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    sw1  = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
           ^ (w_r[14] >> 10);
    wnew = sw1 + w_r[9] + sw0 + w_r[0];
    wt   = (rnd_r < 6'd16) ? w_r[0] : wnew;
    s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch = (e & f) ^ (~e & g);
    s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    mj = (a & b) ^ (a & c) ^ (b & c);
    t1 = h + s1 + ch + k_of(rnd_r) + wt;
    t2 = s0 + mj;
    for (int i = 0; i < 8; i++) begin
      h_add[i] = h_r[i] + v_r[i];
    end
  end

  // one word goes into the buffer per cycle in PAD, and in FEED whenever the queue holds a word
  always_comb begin
    take     = 1'b0;
    ins      = 1'b0;
    ins_word = 32'd0;
    bits_sh  = 6'd0;
    if (state_r == ST_FEED && q_valid) begin
      take = 1'b1;
      ins  = 1'b1;
      if (q_item.kind == KIND_LAST && q_item.vbytes != 3'd4) begin
        bits_sh  = 6'(5'(q_item.vbytes) * 5'd8);
        ins_word = (q_item.vbytes == 3'd0) ? {PadByte, 24'd0}
                   : ((q_item.data & ~(32'hFFFF_FFFF >> bits_sh))
                      | ({PadByte, 24'd0} >> bits_sh));
      end else begin
        ins_word = q_item.data;
      end
    end else if (state_r == ST_PAD) begin
      ins = 1'b1;
      if (padfull_r) ins_word = PadWord;
      else if (wcnt_r == 4'd14 && fin_r) ins_word = 32'(len_r[LenW-1:29]);
      else if (wcnt_r == 4'd15 && fin_r) ins_word = {len_r[28:0], 3'b000};
      else ins_word = 32'd0;
    end
  end

  assign q_ready = take;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FEED: begin
        if (take) begin
          if (wcnt_r == 4'd15) state_nxt = ST_ROUND;
          else if (q_item.kind == KIND_LAST) state_nxt = ST_PAD;
        end
      end
      ST_PAD:   if (wcnt_r == 4'd15) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = !tail_r ? ST_FEED : (fin_r ? ST_EMIT : ST_PAD);
      ST_EMIT:  if (out_ready && ocnt_r == 3'd7) state_nxt = ST_FEED;
      default:  state_nxt = ST_FEED;
    endcase
  end

  assign out_valid = (state_r == ST_EMIT);
  assign out_data  = h_r[ocnt_r];
  assign out_last  = (ocnt_r == 3'd7);

  // payload: buffer, working vars
  always_ff @(posedge clk) begin
    if (ins) begin
      w_r[wcnt_r] <= ins_word;
    end
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
      v_r[0] <= t1 + t2; v_r[1] <= a; v_r[2] <= b; v_r[3] <= c;
      v_r[4] <= d + t1;  v_r[5] <= e; v_r[6] <= f; v_r[7] <= g;
    end else if (state_nxt == ST_ROUND) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FEED;
      wcnt_r    <= 4'd0;
      rnd_r     <= 6'd0;
      len_r     <= '0;
      fin_r     <= 1'b0;
      padfull_r <= 1'b0;
      tail_r    <= 1'b0;
      ocnt_r    <= 3'd0;
      for (int i = 0; i < 8; i++) h_r[i] <= h_init(3'(i));
    end else begin
      state_r <= state_nxt;
      if (ins) wcnt_r <= wcnt_r + 4'd1;
      if (take) begin
        len_r <= len_r + LenW'(q_item.vbytes);
        if (q_item.kind == KIND_LAST) begin
          tail_r    <= 1'b1;
          // a full last word still owes its pad word
          padfull_r <= (q_item.vbytes == 3'd4);
          // length fits in this block if pad lands before word 14
          fin_r <= (q_item.vbytes == 3'd4) ? (wcnt_r < 4'd13) : (wcnt_r < 4'd14);
        end
      end
      if (state_r == ST_PAD && padfull_r) begin
        padfull_r <= 1'b0;
      end
      if (state_r == ST_ADD && tail_r && !fin_r) begin
        fin_r <= 1'b1;   // overflow block finished, next one carries length
      end
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 6'd1;
      if (state_r == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_add[i];
      end
      if (state_r == ST_EMIT && out_ready) begin
        ocnt_r <= ocnt_r + 3'd1;
        if (ocnt_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_init(3'(i));
          len_r  <= '0;
          fin_r  <= 1'b0;
          tail_r <= 1'b0;
        end
      end
    end
  end

  a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && rnd_r == 6'd63 |=> state_r == ST_ADD) else $error("round count");
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_ROUND && state_nxt == ST_ROUND |-> wcnt_r == 4'd15 && ins)
    else $error("block started short");
  a_emit_chain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !take) else $error("input taken during digest output");
  a_emit_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> $past(state_r) == ST_ADD) else $error("emit entry");

endmodule

// ===== src/sha256_message_digest_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 message digest core
// streaming sha-256: message words in, eight digest words out per message
// ----------------------------------------------------------------------------
//   channel | dir | tdata                               | tuser | tlast
//   s_axis  | in  | [31:0] data_word, [34:32] valid_bytes | -     | last_word
//   m_axis  | out | [31:0] digest_word                    | -     | digest_last
//
// each 16-word block is fed from the queue, then run through the 64 rounds
// and the add step in the single shared round unit; a two-entry queue sits in front.
// padding words are generated one a cycle, with one extra block when the
// length does not fit. the eight digest words are sent in order, h0 first.
// rst_n is synchronous; output stalls hold the back end, then the queue
// fills and drops s_axis_tready.
module sha256_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_word, valid_bytes, zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic        m_axis_tlast
);
  import sha256_pkg::*;

  logic   q_valid, q_ready;
  qitem_t q_item;

  sha256_front u_front (
    .clk, .rst_n,
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata[31:0]),
    .in_vbytes (s_axis_tdata[34:32]),
    .in_last   (s_axis_tlast),
    .q_valid, .q_ready, .q_item
  );

  sha256_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_item,
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
